FILE: hw/rtl/fmct_pkg.sv
package fmct_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int DATA_BITS_DEF = 16;

  // Control byte layout.
  localparam int CTL_W      = 8;
  localparam int CTL_RDONLY = 0;
  localparam int CTL_SYNC   = 1;
  localparam int CTL_DELTA  = 2;
  localparam int CTL_BREAK  = 3;

  typedef enum logic [2:0] {
    FN_READ   = 3'd0,
    FN_GWRITE = 3'd1,
    FN_HWRITE = 3'd2,
    FN_FREAD  = 3'd3,
    FN_FSET   = 3'd4,
    FN_FCLR   = 3'd5,
    FN_BRK    = 3'd6,
    FN_SACK   = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

FILE: hw/rtl/fmct_mem.sv
module fmct_mem import fmct_pkg::*; #(
  parameter int AW = ADDR_BITS_DEF,
  parameter int DW = DATA_BITS_DEF + CTL_W
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  localparam int Depth = 1 << AW;

  logic [DW-1:0] mem_r [Depth];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/fmct_ctrl.sv
module fmct_ctrl import fmct_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_func,
  input  logic [15:0]                  in_addr,
  input  logic [15:0]                  in_wdata,
  input  logic [7:0]                   in_flag_bits,
  output logic                         out_valid,
  output logic [15:0]                  out_rdata,
  output logic [7:0]                   out_flags_out,
  output logic                         out_scan_pending,
  output logic                         out_write_dropped,
  output logic [ADDR_BITS-1:0]         mem_rd_addr,
  input  logic [DATA_BITS+CTL_W-1:0]   mem_rd_data,
  output logic                         mem_wr_en,
  output logic [ADDR_BITS-1:0]         mem_wr_addr,
  output logic [DATA_BITS+CTL_W-1:0]   mem_wr_data
);

  localparam int EntryW = DATA_BITS + CTL_W;

  state_t                 state_r, state_nxt;
  logic [ADDR_BITS-1:0]   clr_cnt_r, clr_cnt_nxt;
  func_t                  func_r, func_nxt;
  logic [ADDR_BITS-1:0]   addr_r, addr_nxt;
  logic [DATA_BITS-1:0]   wdata_r, wdata_nxt;
  logic [7:0]             fbits_r, fbits_nxt;
  logic                   scan_r, scan_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [15:0]            out_rdata_r, out_rdata_nxt;
  logic [7:0]             out_flags_r, out_flags_nxt;
  logic                   out_scan_r, out_scan_nxt;
  logic                   out_drop_r, out_drop_nxt;

  logic [ADDR_BITS+15:0]  addr_ext;
  logic [DATA_BITS+15:0]  wdata_ext;
  logic [DATA_BITS+15:0]  old_word_ext;
  logic [ADDR_BITS-1:0]   in_addr_m;
  logic [DATA_BITS-1:0]   old_word;
  logic [CTL_W-1:0]       old_ctl;
  logic [DATA_BITS-1:0]   new_word;
  logic [CTL_W-1:0]       new_ctl;
  logic                   dropped;
  logic                   sync_change;
  logic                   accept;

  // Addresses wrap to the memory size; write data is cut to the word width.
  assign addr_ext     = {{ADDR_BITS{1'b0}}, in_addr};
  assign in_addr_m    = addr_ext[ADDR_BITS-1:0];
  assign wdata_ext    = {{DATA_BITS{1'b0}}, in_wdata};
  assign old_word     = mem_rd_data[DATA_BITS-1:0];
  assign old_ctl      = mem_rd_data[EntryW-1 -: CTL_W];
  assign old_word_ext = {16'b0, old_word};
  assign sync_change  = (old_word != wdata_r) && old_ctl[CTL_SYNC];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // The read is issued every idle cycle; its data is used only after a transfer.
  assign mem_rd_addr = in_addr_m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      scan_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    addr_r      <= addr_nxt;
    wdata_r     <= wdata_nxt;
    fbits_r     <= fbits_nxt;
    out_rdata_r <= out_rdata_nxt;
    out_flags_r <= out_flags_nxt;
    out_scan_r  <= out_scan_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    func_nxt      = func_r;
    addr_nxt      = addr_r;
    wdata_nxt     = wdata_r;
    fbits_nxt     = fbits_r;
    scan_nxt      = scan_r;
    out_valid_nxt = 1'b0;
    out_rdata_nxt = out_rdata_r;
    out_flags_nxt = out_flags_r;
    out_scan_nxt  = out_scan_r;
    out_drop_nxt  = out_drop_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = addr_r;
    mem_wr_data   = '0;
    new_word      = old_word;
    new_ctl       = old_ctl;
    dropped       = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {ADDR_BITS{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          func_nxt  = func_t'(in_func);
          addr_nxt  = in_addr_m;
          wdata_nxt = wdata_ext[DATA_BITS-1:0];
          fbits_nxt = in_flag_bits;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (func_r)
          FN_READ: begin
          end
          FN_GWRITE: begin
            if (old_ctl[CTL_RDONLY]) begin
              dropped = 1'b1;
            end else begin
              new_word = wdata_r;
              if (sync_change) begin
                scan_nxt = 1'b1;
              end
            end
          end
          FN_HWRITE: begin
            new_word = wdata_r;
            if (sync_change) begin
              scan_nxt           = 1'b1;
              new_ctl[CTL_DELTA] = 1'b1;
            end
          end
          FN_FREAD: new_ctl[CTL_DELTA] = 1'b0;
          FN_FSET:  new_ctl = old_ctl | fbits_r;
          FN_FCLR:  new_ctl = old_ctl & ~fbits_r;
          FN_BRK:   new_ctl[CTL_BREAK] = ~old_ctl[CTL_BREAK];
          FN_SACK:  scan_nxt = 1'b0;
          default: begin
          end
        endcase
        // Every operation writes the entry back, changed or not.
        mem_wr_en     = 1'b1;
        mem_wr_addr   = addr_r;
        mem_wr_data   = {new_ctl, new_word};
        out_valid_nxt = 1'b1;
        out_rdata_nxt = old_word_ext[15:0];
        out_flags_nxt = old_ctl;
        out_scan_nxt  = scan_nxt;
        out_drop_nxt  = dropped;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_rdata         = out_rdata_r;
  assign out_flags_out     = out_flags_r;
  assign out_scan_pending  = out_scan_r;
  assign out_write_dropped = out_drop_r;

endmodule

FILE: hw/rtl/flagged_memory_with_change_tracking.sv
// Word memory where each word carries a control byte (read-only, sync, delta,
// break) and a sticky scan flag records changes to sync-marked words.
// Command channel: an operation (in_func, in_addr, in_wdata, in_flag_bits) is
// transferred at a rising edge where start is high and busy is low.
// Result channel: out_valid is high for exactly one cycle with out_rdata,
// out_flags_out, out_scan_pending and out_write_dropped; the receiver takes
// that transfer at the edge ending the cycle and cannot hold it off.
// Each operation is one read-modify-write of a single memory entry: the entry
// is read in the transfer cycle, modified and written back in the following
// cycle, and the result appears in the cycle after that. Busy is high for the
// write-back cycle, so no new operation is taken while one is being written
// back. The memory has one read port, one write port and registered read data.
// After reset the block walks through the memory writing zeros to all
// 2**ADDR_BITS entries (65536 at the default size), one entry a cycle; busy
// stays high during that pass and the scan flag is cleared.
module flagged_memory_with_change_tracking import fmct_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_addr,
  input  logic [15:0] in_wdata,
  input  logic [7:0]  in_flag_bits,
  output logic        out_valid,
  output logic [15:0] out_rdata,
  output logic [7:0]  out_flags_out,
  output logic        out_scan_pending,
  output logic        out_write_dropped
);

  localparam int EntryW = DATA_BITS + CTL_W;

  logic [ADDR_BITS-1:0] mem_rd_addr;
  logic [EntryW-1:0]    mem_rd_data;
  logic                 mem_wr_en;
  logic [ADDR_BITS-1:0] mem_wr_addr;
  logic [EntryW-1:0]    mem_wr_data;

  fmct_ctrl #(
    .ADDR_BITS(ADDR_BITS),
    .DATA_BITS(DATA_BITS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_addr           (in_addr),
    .in_wdata          (in_wdata),
    .in_flag_bits      (in_flag_bits),
    .out_valid         (out_valid),
    .out_rdata         (out_rdata),
    .out_flags_out     (out_flags_out),
    .out_scan_pending  (out_scan_pending),
    .out_write_dropped (out_write_dropped),
    .mem_rd_addr       (mem_rd_addr),
    .mem_rd_data       (mem_rd_data),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data)
  );

  fmct_mem #(
    .AW(ADDR_BITS),
    .DW(EntryW)
  ) u_mem (
    .clk     (clk),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule

FILE: hw/rtl/fmct_checker.sv
module fmct_checker import fmct_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_func,
  input logic       out_valid,
  input logic       out_scan_pending,
  input logic       out_write_dropped
);

  logic accept;
  assign accept = start && !busy;

  // Every transfer produces its result on out_valid after its write-back cycle.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("result missing two cycles after a command transfer");

  // Results never come back to back, since each takes a write-back cycle.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // A scan acknowledge reports the scan flag as cleared in its own result.
  a_sack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FN_SACK) |=> ##1 !out_scan_pending)
    else $error("scan acknowledge result still shows scan pending");

  // Only a guarded write can report a dropped write.
  a_drop_only_gwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func != FN_GWRITE) |=> ##1 !out_write_dropped)
    else $error("dropped write reported for an operation that is not a guarded write");

endmodule

bind flagged_memory_with_change_tracking fmct_checker u_fmct_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_func           (in_func),
  .out_valid         (out_valid),
  .out_scan_pending  (out_scan_pending),
  .out_write_dropped (out_write_dropped)
);
